[hw/rtl/mtss_pkg.sv]
package mtss_pkg;

	// Field widths fixed by the interface
	localparam int IDX_W     = 16;
	localparam int PERIOD_W  = 32;
	localparam int TONE_W    = 48;
	localparam int FREQ_W    = 32;
	localparam int AMP_W     = 16;
	localparam int TIME_W    = 48;
	localparam int HUND_W    = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 48;

	// Sine magnitude is Q0.15 with the sign kept apart, so 15 bits
	localparam int SINE_W = 15;
	localparam int PROD_W = AMP_W + SINE_W;
	// Five tones of at most 65535 * 32767 each, plus sign
	localparam int ACC_W  = 35;

	localparam int MAX_TONES      = 5;
	localparam int NUM_TONES_DEF  = 5;
	localparam int PHASE_BITS_DEF = 12;

	// Final scaling: floor(acc * 100 / 2^23)
	localparam int SCALE      = 100;
	localparam int SCALE_W    = 7;
	localparam int FRAC_SHIFT = 23;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'h0001_0000;

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;
	localparam logic [63:0] MASK32      = 64'h0000_0000_FFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_PERIOD = 3'd0,
		REG_TONE0         = 3'd1,
		REG_TONE1         = 3'd2,
		REG_TONE2         = 3'd3,
		REG_TONE3         = 3'd4,
		REG_TONE4         = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [AMP_W-1:0]  amp;
	} tone_cfg_t;

	// What one cell hands to the next
	typedef struct packed {
		logic                    vld;
		logic [TIME_W-1:0]       t;
		logic signed [ACC_W-1:0] acc;
	} pipe_t;

	// Q4.60 product, keeping bits 123..60 of the full product
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// sin(pi/2 * j / 2^s) rounded to Q0.15, elaboration-time only
	function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] j,
	                                                    input int unsigned s);
		logic [63:0] ph;
		logic [63:0] pl;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] mag;
		ph = (HALF_PI_Q60 >> 32) * j;
		pl = (HALF_PI_Q60 & MASK32) * j;
		x = (ph << (32 - s)) + (pl >> s);
		x2 = mul_q60(x, x);
		term = x;
		sum = x;
		term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
		term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
		term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
		term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
		term = mul_q60(term, x2) / 64'd110; sum = sum - term;
		term = mul_q60(term, x2) / 64'd156; sum = sum + term;
		term = mul_q60(term, x2) / 64'd210; sum = sum - term;
		term = mul_q60(term, x2) / 64'd272; sum = sum + term;
		term = mul_q60(term, x2) / 64'd342; sum = sum - term;
		term = mul_q60(term, x2) / 64'd420; sum = sum + term;
		term = mul_q60(term, x2) / 64'd506; sum = sum - term;
		term = mul_q60(term, x2) / 64'd600; sum = sum + term;
		term = mul_q60(term, x2) / 64'd702; sum = sum - term;
		term = mul_q60(term, x2) / 64'd812; sum = sum + term;
		mag = (sum + (64'd1 << 44)) >> 45;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return mag[SINE_W-1:0];
	endfunction

endpackage

[hw/rtl/mtss_ram.sv]
module mtss_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/mtss_cell.sv]
module mtss_cell #(
	parameter int PHASE_BITS = mtss_pkg::PHASE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  mtss_pkg::tone_cfg_t         tone,
	input  logic                        fill_we,
	input  logic [PHASE_BITS-2:0]       fill_addr,
	input  logic [mtss_pkg::SINE_W-1:0] fill_data,
	input  mtss_pkg::pipe_t             pin,
	output mtss_pkg::pipe_t             pout
);

	import mtss_pkg::*;

	localparam int QA_W    = PHASE_BITS - 1;
	localparam int QDEPTH  = (1 << (PHASE_BITS - 2)) + 1;
	localparam int QUARTER = 1 << (PHASE_BITS - 2);

	logic [FREQ_W-1:0]       phase;
	logic [QA_W-1:0]         raddr;
	logic [SINE_W-1:0]       mag;
	logic [PROD_W-1:0]       prod;
	logic signed [ACC_W-1:0] term;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic [TIME_W-1:0]       t_s1, t_s2, t_s3, t_s4;
	logic signed [ACC_W-1:0] acc_s1, acc_s2, acc_s3, acc_s4;
	logic [PHASE_BITS-1:0]   addr_s1;
	logic                    neg_s2, neg_s3;
	logic [PROD_W-1:0]       prod_s3;

	// Low word of frequency * time is the turn fraction
	assign phase = tone.freq * pin.t[FREQ_W-1:0];

	// Fold odd quadrants onto the stored quarter wave
	always_comb begin
		if (addr_s1[PHASE_BITS-2]) begin
			raddr = QA_W'(QUARTER) - {1'b0, addr_s1[PHASE_BITS-3:0]};
		end else begin
			raddr = {1'b0, addr_s1[PHASE_BITS-3:0]};
		end
	end

	mtss_ram #(
		.WIDTH(SINE_W),
		.DEPTH(QDEPTH)
	) u_rom (
		.clk  (clk),
		.we   (fill_we),
		.waddr(fill_addr),
		.wdata(fill_data),
		.re   (en),
		.raddr(raddr),
		.rdata(mag)
	);

	assign prod = PROD_W'(tone.amp) * PROD_W'(mag);

	always_comb begin
		term = signed'(ACC_W'(prod_s3));
		if (neg_s3) begin
			term = -term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pin.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= pin.t;
			acc_s1  <= pin.acc;
			addr_s1 <= phase[FREQ_W-1 -: PHASE_BITS];
			t_s2    <= t_s1;
			acc_s2  <= acc_s1;
			neg_s2  <= addr_s1[PHASE_BITS-1];
			t_s3    <= t_s2;
			acc_s3  <= acc_s2;
			neg_s3  <= neg_s2;
			prod_s3 <= prod;
			t_s4    <= t_s3;
			acc_s4  <= acc_s3 + term;
		end
	end

	assign pout.vld = vld_s4;
	assign pout.t   = t_s4;
	assign pout.acc = acc_s4;

endmodule

[hw/rtl/multi_tone_sine_sampler_unit.sv]
// Multi-tone sine sampler.
// Input channel (in_valid / in_stall / sample_index): one word per sample
// number. Output channel (out_valid / out_stall): sample_hundredths, the
// floored sum of the tones in units of 0.01, and sample_time, index * period
// in Q32.16 seconds. Config channel (cfg_valid / cfg_ready / cfg_index /
// cfg_data): register 0 is the sample period, 1..5 the tone settings
// (frequency in bits 47..16, amplitude in bits 15..0). Writes to other
// indexes are dropped. Write config only while the block is idle.
// The pipeline holds a register for the time multiply, the stage registers
// of each tone cell, and the output register for the x100 scaling.
// Throughput is one word per cycle unless out_stall holds the pipeline;
// every cell stage advances together.
// After reset the quarter-wave sine tables are loaded, one entry a cycle,
// 2^(PHASE_BITS-2) + 1 entries (1025 by default), with in_stall held high.
// Config writes are taken during that time.
// When out_stall is high with a word waiting, the whole pipeline holds and
// in_stall rises; nothing is dropped.
module multi_tone_sine_sampler_unit #(
	parameter int NUM_TONES  = mtss_pkg::NUM_TONES_DEF,
	parameter int PHASE_BITS = mtss_pkg::PHASE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mtss_pkg::IDX_W-1:0]     sample_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [mtss_pkg::HUND_W-1:0] sample_hundredths,
	output logic [mtss_pkg::TIME_W-1:0]    sample_time,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mtss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mtss_pkg::CFG_W-1:0]     cfg_data
);

	import mtss_pkg::*;

	localparam int QA_W     = PHASE_BITS - 1;
	localparam int QDEPTH   = (1 << (PHASE_BITS - 2)) + 1;
	localparam int SCALED_W = ACC_W + SCALE_W;

	typedef logic [SINE_W-1:0] qtab_t [QDEPTH];

	// Quarter-wave table, built at elaboration
	function automatic qtab_t build_qtab();
		qtab_t tab;
		for (int j = 0; j < QDEPTH; j++) begin
			tab[j] = quarter_sine(64'(j), PHASE_BITS - 2);
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// Config registers
	logic [PERIOD_W-1:0] period_q;
	logic [TONE_W-1:0]   tone_q [MAX_TONES];

	// Table load sequencer
	logic            fill_busy_q;
	logic [QA_W-1:0] fill_addr_q;

	// Pipeline control: advance unless a finished word is held back
	logic en;
	logic accept;

	logic              vld_s1;
	logic [TIME_W-1:0] t_s1;

	pipe_t chain [NUM_TONES+1];

	logic signed [SCALED_W-1:0] scaled;

	logic                     out_vld_q;
	logic signed [HUND_W-1:0] hund_q;
	logic [TIME_W-1:0]        time_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			for (int k = 0; k < MAX_TONES; k++) begin
				tone_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_PERIOD: period_q  <= cfg_data[PERIOD_W-1:0];
				REG_TONE0:         tone_q[0] <= cfg_data[TONE_W-1:0];
				REG_TONE1:         tone_q[1] <= cfg_data[TONE_W-1:0];
				REG_TONE2:         tone_q[2] <= cfg_data[TONE_W-1:0];
				REG_TONE3:         tone_q[3] <= cfg_data[TONE_W-1:0];
				REG_TONE4:         tone_q[4] <= cfg_data[TONE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_busy_q <= 1'b1;
			fill_addr_q <= '0;
		end else if (fill_busy_q) begin
			if (fill_addr_q == QA_W'(QDEPTH - 1)) begin
				fill_busy_q <= 1'b0;
			end else begin
				fill_addr_q <= fill_addr_q + QA_W'(1);
			end
		end
	end

	assign en       = !out_vld_q || !out_stall;
	assign in_stall = fill_busy_q || !en;
	assign accept   = in_valid && !in_stall;

	// Head stage: sample time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= TIME_W'(sample_index) * TIME_W'(period_q);
		end
	end

	assign chain[0].vld = vld_s1;
	assign chain[0].t   = t_s1;
	assign chain[0].acc = '0;

	// One cell per tone; each adds its term to the running sum
	for (genvar k = 0; k < NUM_TONES; k++) begin : g_cell
		tone_cfg_t tone;

		assign tone.freq = tone_q[k][TONE_W-1:AMP_W];
		assign tone.amp  = tone_q[k][AMP_W-1:0];

		mtss_cell #(
			.PHASE_BITS(PHASE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.tone     (tone),
			.fill_we  (fill_busy_q),
			.fill_addr(fill_addr_q),
			.fill_data(QTAB[fill_addr_q]),
			.pin      (chain[k]),
			.pout     (chain[k+1])
		);
	end

	// floor(acc * 100 / 2^23): arithmetic shift floors toward minus infinity
	assign scaled = SCALED_W'(chain[NUM_TONES].acc) * SCALED_W'(SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= chain[NUM_TONES].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hund_q <= HUND_W'(scaled >>> FRAC_SHIFT);
			time_q <= chain[NUM_TONES].t;
		end
	end

	assign out_valid         = out_vld_q;
	assign sample_hundredths = hund_q;
	assign sample_time       = time_q;

endmodule
